[sv/bfpa_pkg.sv]
// bfpa_pkg: shared types, sizes and helper functions of the best-fit partition allocator
// no dependencies; imported by bfpa_store, bfpa_scan and best_fit_partition_allocator_core
package bfpa_pkg;

  localparam int MAX_PARTITIONS = 64;
  localparam int SIZE_BITS      = 16;

  localparam int IDX_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_PARTITIONS + 1);
  localparam int FIELD_W = 16;
  localparam int BIDX_W  = 6;
  localparam int SUM_W   = 22;
  localparam int UNP_W   = 32;
  localparam int ADD_W   = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;
  localparam int UADD_W  = UNP_W + 1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [UNP_W-1:0]     unp_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_LOADED   = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_GRANTED  = 2'd2,
    STATUS_UNPLACED = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [FIELD_W-1:0]   size_value;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [BIDX_W-1:0]    block_index;
    logic [FIELD_W-1:0]   leftover;
    logic [SUM_W-1:0]     internal_frag_total;
    logic                 external_frag;
  } res_t;

  // write port of the partition store
  typedef struct packed {
    logic  en;
    idx_t  idx;
    size_t size;
  } wr_t;

  // used-flag update
  typedef struct packed {
    logic en;
    logic set;
    idx_t idx;
  } flag_t;

  // registered read beat from the store
  typedef struct packed {
    logic  valid;
    idx_t  idx;
    size_t size;
    logic  used;
  } rd_t;

  // best candidate held by the scan unit
  typedef struct packed {
    logic  found;
    idx_t  idx;
    size_t size;
  } best_t;

  function automatic size_t fit_size(logic [FIELD_W-1:0] v);
    size_t r;
    r = '0;
    for (int i = 0; i < SIZE_BITS; i++) begin
      if (i < FIELD_W) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(size_t v);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < SIZE_BITS) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [BIDX_W-1:0] to_block_index(idx_t v);
    logic [BIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < BIDX_W; i++) begin
      if (i < IDX_W) r[i] = v[i];
    end
    return r;
  endfunction

  function automatic sum_t sat_sum(sum_t acc, size_t add);
    logic [ADD_W-1:0] s;
    s = ADD_W'(acc) + ADD_W'(add);
    if (s > ADD_W'({SUM_W{1'b1}})) return {SUM_W{1'b1}};
    return s[SUM_W-1:0];
  endfunction

  function automatic unp_t sat_unp(unp_t acc, size_t add);
    logic [UADD_W-1:0] s;
    s = UADD_W'(acc) + UADD_W'(add);
    if (s[UNP_W]) return {UNP_W{1'b1}};
    return s[UNP_W-1:0];
  endfunction

endpackage

[sv/bfpa_store.sv]
// bfpa_store: partition size memory with registered read and the used flags
// depends on bfpa_pkg
module bfpa_store import bfpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  wr_t   wr_i,
  input  flag_t flag_i,
  input  logic  rd_en_i,
  input  idx_t  rd_idx_i,
  output rd_t   rd_o
);

  size_t                     mem_q [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] used_q;
  logic                      rd_valid_q;
  idx_t                      rd_idx_q;
  size_t                     rd_size_q;
  logic                      rd_used_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.size;
    end
    if (rd_en_i) begin
      rd_size_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      rd_used_q  <= 1'b0;
    end else begin
      if (flag_i.en) begin
        used_q[flag_i.idx] <= flag_i.set;
      end
      rd_valid_q <= rd_en_i;
      if (rd_en_i) begin
        rd_idx_q  <= rd_idx_i;
        rd_used_q <= used_q[rd_idx_i];
      end
    end
  end

  assign rd_o = '{valid: rd_valid_q, idx: rd_idx_q, size: rd_size_q, used: rd_used_q};

endmodule

[sv/bfpa_scan.sv]
// bfpa_scan: shared compare unit that keeps the smallest free fitting partition
// depends on bfpa_pkg; fed one read beat per cycle from bfpa_store
module bfpa_scan import bfpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clear_i,
  input  size_t req_size_i,
  input  rd_t   rd_i,
  output best_t best_o
);

  logic  found_q, found_d;
  idx_t  idx_q, idx_d;
  size_t size_q, size_d;
  logic  take;

  assign take = rd_i.valid && !rd_i.used && (req_size_i <= rd_i.size)
                && (!found_q || (rd_i.size < size_q));

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    size_d  = size_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      idx_d   = rd_i.idx;
      size_d  = rd_i.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    size_q <= size_d;
  end

  assign best_o = '{found: found_q, idx: idx_q, size: size_q};

endmodule

[sv/best_fit_partition_allocator_core.sv]
// best_fit_partition_allocator_core: sequencer, running sums and result register
// depends on bfpa_pkg, bfpa_store, bfpa_scan
//
//  channel   ports                          handshake
//  command   start, req_i, busy             beat taken when start && !busy
//  result    result_valid_o, res_o          one-cycle strobe, no back-pressure
//
// a load runs S_LOAD, S_REPORT; a request runs S_SCAN, S_DRAIN, S_UPDATE, S_REPORT, or on an
// empty table S_UPDATE, S_REPORT (one partition read and compared per cycle, single store read port)
// busy is high from the cycle after acceptance until the result is registered
// reset clears the used flags, count and sums at once; sizes hold garbage until loaded
// the result strobe lasts one cycle and cannot be stalled
module best_fit_partition_allocator_core import bfpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output res_t res_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_REPORT = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  sum_t    free_q, free_d;
  sum_t    internal_q, internal_d;
  unp_t    unplaced_q, unplaced_d;
  idx_t    rd_idx_q, rd_idx_d;
  opcode_e op_q;
  size_t   sz_q;
  status_e status_q, status_d;
  idx_t    idx_q, idx_d;
  size_t   left_q, left_d;
  logic    valid_q, valid_d;
  res_t    res_q;

  logic    accept;
  logic    full;
  logic    last;
  wr_t     wr;
  flag_t   flag;
  logic    rd_en;
  rd_t     rd;
  best_t   best;
  size_t   left_w;

  assign accept = start && !busy;
  assign full   = (count_q == cnt_t'(MAX_PARTITIONS));
  assign last   = ((cnt_t'(rd_idx_q) + cnt_t'(1)) == count_q);
  assign left_w = best.size - sz_q;
  assign rd_en  = (state_q == S_SCAN);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    free_d     = free_q;
    internal_d = internal_q;
    unplaced_d = unplaced_q;
    rd_idx_d   = rd_idx_q;
    status_d   = status_q;
    idx_d      = idx_q;
    left_d     = left_q;
    valid_d    = 1'b0;
    wr         = '{en: 1'b0, idx: count_q[IDX_W-1:0], size: sz_q};
    flag       = '{en: 1'b0, set: 1'b0, idx: count_q[IDX_W-1:0]};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_idx_d = '0;
          if (req_i.opcode == OP_LOAD) begin
            state_d = S_LOAD;
          end else if (count_q == '0) begin
            state_d = S_UPDATE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        left_d = '0;
        if (full) begin
          status_d = STATUS_REJECTED;
          idx_d    = '0;
        end else begin
          wr.en    = 1'b1;
          flag.en  = 1'b1;
          status_d = STATUS_LOADED;
          idx_d    = count_q[IDX_W-1:0];
          count_d  = count_q + cnt_t'(1);
          free_d   = sat_sum(free_q, sz_q);
        end
        state_d = S_REPORT;
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + idx_t'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (best.found) begin
          flag       = '{en: 1'b1, set: 1'b1, idx: best.idx};
          status_d   = STATUS_GRANTED;
          idx_d      = best.idx;
          left_d     = left_w;
          internal_d = sat_sum(internal_q, left_w);
          if (ADD_W'(free_q) >= ADD_W'(best.size)) begin
            free_d = free_q - SUM_W'(best.size);
          end else begin
            free_d = '0;
          end
        end else begin
          status_d   = STATUS_UNPLACED;
          idx_d      = '0;
          left_d     = '0;
          unplaced_d = sat_unp(unplaced_q, sz_q);
        end
        state_d = S_REPORT;
      end
      S_REPORT: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      free_q     <= '0;
      internal_q <= '0;
      unplaced_q <= '0;
      rd_idx_q   <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      free_q     <= free_d;
      internal_q <= internal_d;
      unplaced_q <= unplaced_d;
      rd_idx_q   <= rd_idx_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.opcode;
      sz_q <= fit_size(req_i.size_value);
    end
    status_q <= status_d;
    idx_q    <= idx_d;
    left_q   <= left_d;
    if (state_q == S_REPORT) begin
      res_q.status              <= status_q;
      res_q.block_index         <= to_block_index(idx_q);
      res_q.leftover            <= to_field(left_q);
      res_q.internal_frag_total <= internal_q;
      res_q.external_frag       <= (UNP_W'(free_q) > unplaced_q);
    end
  end

  bfpa_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .flag_i   (flag),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx_q),
    .rd_o     (rd)
  );

  bfpa_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept),
    .req_size_i (sz_q),
    .rd_i       (rd),
    .best_o     (best)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign res_o          = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MAX_PARTITIONS))
    else $error("partition count beyond table depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0) && (op_q == OP_REQUEST))
    else $error("scan without loaded partitions or for a load");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && ($past(state_q) == S_REPORT))
    else $error("result strobe without report step");

  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) && best.found |-> (best.size >= sz_q))
    else $error("granted partition smaller than request");

endmodule
